// ===== hdl/bmii_pkg.sv =====
`default_nettype none

package bmii_pkg;

   localparam int SUM_W = 15;
   localparam int CFG_W = 8;
   localparam int CSR_AW = 1;

   localparam logic [CSR_AW-1:0] CSR_MAP_WIDTH = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_MAP_HEIGHT = 1'd1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = 2;
   localparam int FIFO_CW = 3;

   typedef struct packed {
      logic             last;
      logic [SUM_W-1:0] sum;
   } bmii_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/bmii_rsp_fifo.sv =====
`default_nettype none

module bmii_rsp_fifo
   import bmii_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire bmii_rsp_type       push_data,
   input  wire logic               pop,
   output logic                    out_valid,
   output bmii_rsp_type            out_data,
   output logic [FIFO_CW-1:0]      level
);

   bmii_rsp_type          store_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]    wr_ptr_ff;
   logic [FIFO_AW-1:0]    rd_ptr_ff;
   logic [FIFO_CW-1:0]    cnt_ff;
   logic                  do_pop;

   assign do_pop = pop && (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, do_pop})
            2'b10: cnt_ff <= cnt_ff + 1'b1;
            2'b01: cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (cnt_ff != '0);
   assign out_data = store_ff[rd_ptr_ff];
   assign level = cnt_ff;

endmodule

`default_nettype wire

// ===== hdl/binary_map_integral_image.sv =====
// Streaming summed-area table of a binary map.
// req_*: one cell per transaction in raster order, req_tdata[0] = blocked.
// rsp_*: one transaction per cell, rsp_tdata[14:0] = blocked count from the
//   origin to that cell inclusive, rsp_tlast high on the final cell of the map.
// csr_*: csr_addr 0 = map width, 1 = map height (0 acts as 1, values above
//   MAX_COLS / MAX_ROWS act as the maximum). Write only while idle.
// Throughput: one cell per cycle while req_tready is high. rsp_tvalid rises
//   once the cell has passed the s1 register and been written into the
//   output queue; the line store is read in the cycle of acceptance and
//   written in the cycle after, and a 4-entry output queue holds results.
// A one-column map reads the entry that is being written in the same cycle; that
//   value is forwarded around the line store.
// When rsp_tready is low the output queue fills and req_tready drops once the
//   queue plus the in-flight cell reach its depth; nothing is lost.
// Reset: position, row sum, pipeline and queue cleared, sizes back to 80x80.
//   The line store is not cleared; row 0 never reads it.
`default_nettype none

module binary_map_integral_image
   import bmii_pkg::*;
#(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // [0] blocked
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [15:0]            rsp_tdata,   // [14:0] blocked_sum
   output logic                   rsp_tlast,
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_addr,
   input  wire logic [CFG_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_COLS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int RSW = $clog2(MAX_COLS + 1);
   localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
   localparam int HW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
   localparam logic [WW-1:0] MAXC = WW'(MAX_COLS);
   localparam logic [HW-1:0] MAXR = HW'(MAX_ROWS);

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [RSW-1:0]   rsum_ff, rsum_in;

   logic             s1_v_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [RSW-1:0]   s1_rsum_ff;
   logic             s1_rownz_ff;
   logic             s1_last_ff;
   logic             fwd_ff;
   logic [SUM_W-1:0] fwd_sum_ff;
   logic [SUM_W-1:0] rd_ff;

   logic [SUM_W-1:0] line_mem [MAX_COLS];

   logic [WW-1:0]    w_ext, w_eff;
   logic [HW-1:0]    h_ext, h_eff;
   logic             end_row, end_map, accept;
   logic [SUM_W-1:0] above, s1_sum;
   logic             fwd_hit;

   bmii_rsp_type       push_data, out_data;
   logic               out_valid;
   logic [FIFO_CW-1:0] fifo_level;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= CFG_W'(80);
         height_ff <= CFG_W'(80);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MAP_WIDTH: width_ff <= csr_wdata;
            CSR_MAP_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      w_ext = WW'(width_ff);
      h_ext = HW'(height_ff);
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (w_ext > MAXC) begin
         w_eff = MAXC;
      end else begin
         w_eff = w_ext;
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (h_ext > MAXR) begin
         h_eff = MAXR;
      end else begin
         h_eff = h_ext;
      end
   end

   assign req_tready = ({1'b0, fifo_level} + {{FIFO_CW{1'b0}}, s1_v_ff})
                       < (FIFO_CW + 1)'(FIFO_DEPTH);
   assign accept = req_tvalid && req_tready;

   assign end_row = (WW'(col_ff) + WW'(1)) >= w_eff;
   assign end_map = end_row && ((HW'(row_ff) + HW'(1)) >= h_eff);
   assign fwd_hit = s1_v_ff && (s1_col_ff == col_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      rsum_in = rsum_ff;
      if (accept) begin
         if (col_ff == '0) begin
            rsum_in = RSW'(req_tdata[0]);
         end else begin
            rsum_in = rsum_ff + RSW'(req_tdata[0]);
         end
         if (end_row) begin
            col_in = '0;
            row_in = end_map ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         rsum_ff <= '0;
         s1_v_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         rsum_ff <= rsum_in;
         s1_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff <= col_ff;
         s1_rsum_ff <= rsum_in;
         s1_rownz_ff <= (row_ff != '0);
         s1_last_ff <= end_map;
         fwd_ff <= fwd_hit;
         fwd_sum_ff <= s1_sum;
         rd_ff <= line_mem[col_ff];
      end
   end

   // line store: read at acceptance, written in the cycle after
   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         line_mem[s1_col_ff] <= s1_sum;
      end
   end

   assign above = s1_rownz_ff ? (fwd_ff ? fwd_sum_ff : rd_ff) : '0;
   assign s1_sum = above + {{(SUM_W - RSW){1'b0}}, s1_rsum_ff};

   assign push_data.last = s1_last_ff;
   assign push_data.sum = s1_sum;

   bmii_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_v_ff),
      .push_data (push_data),
      .pop       (rsp_tready),
      .out_valid (out_valid),
      .out_data  (out_data),
      .level     (fifo_level)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata = {1'b0, out_data.sum};
   assign rsp_tlast = out_data.last;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !(rsp_tvalid && rsp_tready) |-> fifo_level < FIFO_CW'(FIFO_DEPTH))
      else $error("response queue overflow");

   a_fwd_col0: assert property (@(posedge clock) disable iff (reset)
      accept && fwd_hit |-> col_ff == '0)
      else $error("line store forward at nonzero column");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && !s1_v_ff)
      else $error("result pending after reset");

endmodule

`default_nettype wire
